// ===== sv/tpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types, constants and table functions for the tilt position estimator.
// ----------------------------------------------------------------------------
package tpe_pkg;

  localparam int MOTOR_STEP_MULT  = 23;
  localparam int TABLE_LAST_INDEX = 90;
  localparam int ANGLE_W          = 16;
  localparam int IDX_W            = 7;
  localparam int TAB_W            = 10;
  localparam int POS_W            = 18;
  localparam int SETUP_W          = 24;
  localparam int STEP_W           = 16;
  localparam int STEP23_W         = 21;
  localparam int PROD_W           = 39;
  localparam int TIME_W           = 31;
  localparam int NUM_W            = 49;
  localparam int QUO_W            = 18;
  localparam int DIV_CNT_W        = 5;
  localparam int SRCH_CNT_W       = 3;
  localparam int CFG_DATA_W       = 31;
  localparam int CFG_IDX_W        = 3;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(TABLE_LAST_INDEX * 256);
  localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(907 * 256);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP_SETUP   = 3'd0,
    CFG_DOWN_SETUP = 3'd1,
    CFG_UP_STEP    = 3'd2,
    CFG_DOWN_STEP  = 3'd3,
    CFG_MAX_TRANS  = 3'd4,
    CFG_MAX_CAL    = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_MUL, ST_TRANS, ST_CHK, ST_NUM, ST_DINIT, ST_DIV,
    ST_TGT, ST_SINIT, ST_SRCH, ST_D2INIT, ST_DIV2, ST_ANG, ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic calc_pos;
    logic calc_prod;
    logic calc_transit;
    logic check;
    logic calc_num;
    logic div_init;
    logic div_sel;     // 0: motion ratio, 1: angle fraction
    logic div_step;
    logic calc_tgt;
    logic srch_init;
    logic srch_step;
    logic calc_ang;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic decided;
    logic div_last;
    logic srch_last;
  } status_t;

  typedef struct packed {
    logic [SETUP_W-1:0] up_setup;
    logic [SETUP_W-1:0] down_setup;
    logic [STEP_W-1:0]  up_step;
    logic [STEP_W-1:0]  down_step;
    logic [TIME_W-1:0]  max_trans;
    logic [TIME_W-1:0]  max_cal;
  } cfg_t;

  // Angle-to-step ROM, one entry per degree
  function automatic logic [TAB_W-1:0] step_tab(input logic [IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      7'd0: v = 10'd0;     7'd1: v = 10'd7;     7'd2: v = 10'd14;    7'd3: v = 10'd21;
      7'd4: v = 10'd28;    7'd5: v = 10'd35;    7'd6: v = 10'd42;    7'd7: v = 10'd49;
      7'd8: v = 10'd56;    7'd9: v = 10'd64;    7'd10: v = 10'd71;   7'd11: v = 10'd78;
      7'd12: v = 10'd86;   7'd13: v = 10'd93;   7'd14: v = 10'd101;  7'd15: v = 10'd109;
      7'd16: v = 10'd116;  7'd17: v = 10'd125;  7'd18: v = 10'd134;  7'd19: v = 10'd141;
      7'd20: v = 10'd150;  7'd21: v = 10'd156;  7'd22: v = 10'd165;  7'd23: v = 10'd174;
      7'd24: v = 10'd183;  7'd25: v = 10'd192;  7'd26: v = 10'd201;  7'd27: v = 10'd210;
      7'd28: v = 10'd218;  7'd29: v = 10'd229;  7'd30: v = 10'd239;  7'd31: v = 10'd248;
      7'd32: v = 10'd254;  7'd33: v = 10'd267;  7'd34: v = 10'd277;  7'd35: v = 10'd287;
      7'd36: v = 10'd296;  7'd37: v = 10'd306;  7'd38: v = 10'd316;  7'd39: v = 10'd326;
      7'd40: v = 10'd336;  7'd41: v = 10'd344;  7'd42: v = 10'd356;  7'd43: v = 10'd367;
      7'd44: v = 10'd377;  7'd45: v = 10'd388;  7'd46: v = 10'd398;  7'd47: v = 10'd409;
      7'd48: v = 10'd417;  7'd49: v = 10'd431;  7'd50: v = 10'd440;  7'd51: v = 10'd453;
      7'd52: v = 10'd463;  7'd53: v = 10'd474;  7'd54: v = 10'd487;  7'd55: v = 10'd498;
      7'd56: v = 10'd509;  7'd57: v = 10'd519;  7'd58: v = 10'd531;  7'd59: v = 10'd541;
      7'd60: v = 10'd554;  7'd61: v = 10'd565;  7'd62: v = 10'd576;  7'd63: v = 10'd588;
      7'd64: v = 10'd599;  7'd65: v = 10'd612;  7'd66: v = 10'd622;  7'd67: v = 10'd635;
      7'd68: v = 10'd647;  7'd69: v = 10'd658;  7'd70: v = 10'd670;  7'd71: v = 10'd681;
      7'd72: v = 10'd694;  7'd73: v = 10'd706;  7'd74: v = 10'd719;  7'd75: v = 10'd730;
      7'd76: v = 10'd743;  7'd77: v = 10'd754;  7'd78: v = 10'd766;  7'd79: v = 10'd779;
      7'd80: v = 10'd791;  7'd81: v = 10'd801;  7'd82: v = 10'd812;  7'd83: v = 10'd825;
      7'd84: v = 10'd838;  7'd85: v = 10'd850;  7'd86: v = 10'd860;  7'd87: v = 10'd873;
      7'd88: v = 10'd884;  7'd89: v = 10'd896;  7'd90: v = 10'd907;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  // Table position of an angle (at most 90 degrees), in 1/256 table units
  function automatic logic [POS_W-1:0] angle_pos(input logic [ANGLE_W-1:0] a);
    logic [IDX_W-1:0] i;
    logic [TAB_W-1:0] lo;
    logic [TAB_W-1:0] hi;
    logic [POS_W-1:0] res;
    i  = a[14:8];
    lo = step_tab(i);
    hi = step_tab(i + 7'd1);
    if (a[15:8] >= 8'(TABLE_LAST_INDEX)) begin
      res = POS_MAX;
    end else begin
      res = {lo, 8'd0} + POS_W'(hi - lo) * POS_W'(a[7:0]);
    end
    return res;
  endfunction

endpackage

// ===== sv/tilt_position_estimator.sv =====
// Flow: the result goes to the output register directly when a rule settles it,
//   after the ratio division when the target saturates at a table end, and after
//   two 18-bit divisions on the shared divider plus a table search when interpolating.
// Throughput: one transaction at a time; in_ready returns the cycle after the result
//   is loaded into the output register.
// Reset: synchronous active-low; clears control and restores register defaults.
// ----------------------------------------------------------------------------
// tilt_position_estimator
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module tilt_position_estimator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     in_start_angle,
  input  logic                            in_start_unknown,
  input  logic [15:0]                     in_dest_angle,
  input  logic                            in_dest_unknown,
  input  logic signed [31:0]              in_elapsed_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_reached_angle,
  output logic                            out_reached_unknown
);

  tpe_pkg::cfg_t    cfg_r, cfg_nxt;
  tpe_pkg::cmd_t    cmd;
  tpe_pkg::status_t status;

  // Register writes; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tpe_pkg::CFG_UP_SETUP:   cfg_nxt.up_setup   = cfg_wdata[tpe_pkg::SETUP_W-1:0];
        tpe_pkg::CFG_DOWN_SETUP: cfg_nxt.down_setup = cfg_wdata[tpe_pkg::SETUP_W-1:0];
        tpe_pkg::CFG_UP_STEP:    cfg_nxt.up_step    = cfg_wdata[tpe_pkg::STEP_W-1:0];
        tpe_pkg::CFG_DOWN_STEP:  cfg_nxt.down_step  = cfg_wdata[tpe_pkg::STEP_W-1:0];
        tpe_pkg::CFG_MAX_TRANS:  cfg_nxt.max_trans  = cfg_wdata[tpe_pkg::TIME_W-1:0];
        tpe_pkg::CFG_MAX_CAL:    cfg_nxt.max_cal    = cfg_wdata[tpe_pkg::TIME_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_setup   <= 24'd332192;
      cfg_r.down_setup <= 24'd333390;
      cfg_r.up_step    <= 16'd4269;
      cfg_r.down_step  <= 16'd4291;
      cfg_r.max_trans  <= 31'd94850686;
      cfg_r.max_cal    <= 31'd130537866;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tpe_dp u_dp (
    .clk                 (clk),
    .cfg                 (cfg_r),
    .in_start_angle      (in_start_angle),
    .in_start_unknown    (in_start_unknown),
    .in_dest_angle       (in_dest_angle),
    .in_dest_unknown     (in_dest_unknown),
    .in_elapsed_time     (in_elapsed_time),
    .cmd                 (cmd),
    .status              (status),
    .out_reached_angle   (out_reached_angle),
    .out_reached_unknown (out_reached_unknown)
  );

endmodule

// ===== sv/tpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpe_ctrl
// Sequencer for one estimate: classify, transit time, ratio division, table
// search, fraction division, then hand the result to the output register.
// ----------------------------------------------------------------------------
module tpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tpe_pkg::status_t   status,
  output tpe_pkg::cmd_t      cmd
);

  tpe_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpe_pkg::ST_IDLE:   if (in_valid) state_nxt = tpe_pkg::ST_POS;
      tpe_pkg::ST_POS:    state_nxt = status.decided ? tpe_pkg::ST_OUT : tpe_pkg::ST_MUL;
      tpe_pkg::ST_MUL:    state_nxt = tpe_pkg::ST_TRANS;
      tpe_pkg::ST_TRANS:  state_nxt = tpe_pkg::ST_CHK;
      tpe_pkg::ST_CHK:    state_nxt = tpe_pkg::ST_NUM;
      tpe_pkg::ST_NUM:    state_nxt = status.decided ? tpe_pkg::ST_OUT : tpe_pkg::ST_DINIT;
      tpe_pkg::ST_DINIT:  state_nxt = tpe_pkg::ST_DIV;
      tpe_pkg::ST_DIV:    if (status.div_last) state_nxt = tpe_pkg::ST_TGT;
      tpe_pkg::ST_TGT:    state_nxt = tpe_pkg::ST_SINIT;
      tpe_pkg::ST_SINIT:  state_nxt = status.decided ? tpe_pkg::ST_OUT : tpe_pkg::ST_SRCH;
      tpe_pkg::ST_SRCH:   if (status.srch_last) state_nxt = tpe_pkg::ST_D2INIT;
      tpe_pkg::ST_D2INIT: state_nxt = tpe_pkg::ST_DIV2;
      tpe_pkg::ST_DIV2:   if (status.div_last) state_nxt = tpe_pkg::ST_ANG;
      tpe_pkg::ST_ANG:    state_nxt = tpe_pkg::ST_OUT;
      tpe_pkg::ST_OUT:    if (!out_valid_r || out_ready) state_nxt = tpe_pkg::ST_IDLE;
      default:            state_nxt = tpe_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      tpe_pkg::ST_IDLE:   cmd.load_in      = in_valid;
      tpe_pkg::ST_POS:    cmd.calc_pos     = 1'b1;
      tpe_pkg::ST_MUL:    cmd.calc_prod    = 1'b1;
      tpe_pkg::ST_TRANS:  cmd.calc_transit = 1'b1;
      tpe_pkg::ST_CHK:    cmd.check        = 1'b1;
      tpe_pkg::ST_NUM:    cmd.calc_num     = 1'b1;
      tpe_pkg::ST_DINIT:  cmd.div_init     = 1'b1;
      tpe_pkg::ST_DIV:    cmd.div_step     = 1'b1;
      tpe_pkg::ST_TGT:    cmd.calc_tgt     = 1'b1;
      tpe_pkg::ST_SINIT:  cmd.srch_init    = 1'b1;
      tpe_pkg::ST_SRCH:   cmd.srch_step    = 1'b1;
      tpe_pkg::ST_D2INIT: begin
        cmd.div_init = 1'b1;
        cmd.div_sel  = 1'b1;
      end
      tpe_pkg::ST_DIV2:   cmd.div_step     = 1'b1;
      tpe_pkg::ST_ANG:    cmd.calc_ang     = 1'b1;
      tpe_pkg::ST_OUT:    cmd.load_out     = !out_valid_r || out_ready;
      default:            cmd = '0;
    endcase
  end

  // Hold the result valid until the downstream transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpe_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == tpe_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/tpe_dp.sv =====
// ----------------------------------------------------------------------------
// tpe_dp
// Datapath: input capture and rule checks, table positions, transit time,
// shared restoring divider, inverse table search and the output register.
// ----------------------------------------------------------------------------
module tpe_dp (
  input  logic                          clk,
  input  tpe_pkg::cfg_t                 cfg,
  input  logic [tpe_pkg::ANGLE_W-1:0]   in_start_angle,
  input  logic                          in_start_unknown,
  input  logic [tpe_pkg::ANGLE_W-1:0]   in_dest_angle,
  input  logic                          in_dest_unknown,
  input  logic signed [31:0]            in_elapsed_time,
  input  tpe_pkg::cmd_t                 cmd,
  output tpe_pkg::status_t              status,
  output logic [tpe_pkg::ANGLE_W-1:0]   out_reached_angle,
  output logic                          out_reached_unknown
);

  logic [tpe_pkg::ANGLE_W-1:0]  s_r, d_r;
  logic [tpe_pkg::TIME_W-1:0]   ue_r;
  logic [tpe_pkg::SETUP_W-1:0]  setup_r;
  logic [tpe_pkg::STEP23_W-1:0] step23_r;
  logic [tpe_pkg::POS_W-1:0]    ps_r, pd_r, dp_r, tgt_r;
  logic [tpe_pkg::PROD_W-1:0]   prod_r;
  logic [tpe_pkg::TIME_W-1:0]   transit_r, dt_r;
  logic [tpe_pkg::NUM_W-1:0]    num_r;
  logic [tpe_pkg::TIME_W-1:0]   rem_r, divisor_r;
  logic [tpe_pkg::QUO_W-1:0]    nlo_r, quo_r;
  logic [tpe_pkg::DIV_CNT_W-1:0]  dcnt_r;
  logic [tpe_pkg::IDX_W-1:0]      lo_r;
  logic [tpe_pkg::SRCH_CNT_W-1:0] scnt_r;
  logic                         decided_r;
  logic [tpe_pkg::ANGLE_W-1:0]  res_ang_r, out_ang_r;
  logic                         res_unk_r, out_unk_r;

  logic                         long_el, bad_in, up;
  logic [tpe_pkg::POS_W-1:0]    ps_c, pd_c;
  logic [tpe_pkg::PROD_W:0]     rnd;
  logic [31:0]                  end_time;
  logic [tpe_pkg::TIME_W:0]     trial;
  logic                         qbit;
  logic [tpe_pkg::IDX_W-1:0]    cand;
  logic [tpe_pkg::TAB_W-1:0]    cand_tab, base_tab, next_tab;
  logic [tpe_pkg::POS_W-1:0]    tgt_c, frac_num;

  // Rule checks on the incoming transaction
  always_comb begin
    long_el = $signed({in_elapsed_time[31], in_elapsed_time}) >=
              $signed({2'b00, (in_start_unknown ? cfg.max_cal : cfg.max_trans)});
    bad_in  = in_start_unknown || in_dest_unknown || in_elapsed_time[31] ||
              (in_start_angle > tpe_pkg::ANGLE_MAX) || (in_dest_angle > tpe_pkg::ANGLE_MAX);
    up      = in_start_angle < in_dest_angle;
  end

  assign ps_c     = tpe_pkg::angle_pos(s_r);
  assign pd_c     = tpe_pkg::angle_pos(d_r);
  assign rnd      = {1'b0, prod_r} + (tpe_pkg::PROD_W+1)'(128);
  assign end_time = 32'(setup_r) + 32'(transit_r);
  assign trial    = {rem_r, nlo_r[tpe_pkg::QUO_W-1]};
  assign qbit     = trial >= {1'b0, divisor_r};
  assign cand     = lo_r + (tpe_pkg::IDX_W'(1) << scnt_r);
  assign cand_tab = tpe_pkg::step_tab(cand);
  assign base_tab = tpe_pkg::step_tab(lo_r);
  assign next_tab = tpe_pkg::step_tab(lo_r + tpe_pkg::IDX_W'(1));
  assign frac_num = tgt_r - {base_tab, 8'd0};
  assign tgt_c    = (pd_r >= ps_r) ? ps_r + quo_r : ps_r - quo_r;

  always_ff @(posedge clk) begin
    // Capture and classify
    if (cmd.load_in) begin
      s_r       <= in_start_angle;
      d_r       <= in_dest_angle;
      ue_r      <= in_elapsed_time[tpe_pkg::TIME_W-1:0];
      setup_r   <= up ? cfg.up_setup : cfg.down_setup;
      step23_r  <= tpe_pkg::STEP23_W'((up ? cfg.up_step : cfg.down_step) *
                   tpe_pkg::MOTOR_STEP_MULT);
      decided_r <= long_el || bad_in;
      if (long_el) begin
        res_unk_r <= in_dest_unknown;
        res_ang_r <= in_dest_unknown ? '0 : in_dest_angle;
      end else begin
        res_unk_r <= 1'b1;
        res_ang_r <= '0;
      end
    end
    // Table positions
    if (cmd.calc_pos) begin
      ps_r <= ps_c;
      pd_r <= pd_c;
      dp_r <= (ps_c > pd_c) ? ps_c - pd_c : pd_c - ps_c;
    end
    if (cmd.calc_prod) prod_r <= tpe_pkg::PROD_W'(step23_r) * tpe_pkg::PROD_W'(dp_r);
    if (cmd.calc_transit) transit_r <= rnd[tpe_pkg::PROD_W-1:8];
    // Move complete or still in setup
    if (cmd.check) begin
      dt_r      <= ue_r - tpe_pkg::TIME_W'(setup_r);
      res_unk_r <= 1'b0;
      if (32'(ue_r) >= end_time) begin
        decided_r <= 1'b1;
        res_ang_r <= d_r;
      end else if (ue_r <= tpe_pkg::TIME_W'(setup_r) || transit_r == '0) begin
        decided_r <= 1'b1;
        res_ang_r <= s_r;
      end
    end
    if (cmd.calc_num) num_r <= tpe_pkg::NUM_W'(dp_r) * tpe_pkg::NUM_W'(dt_r);
    // Shared divider: load operands, then one quotient bit per cycle
    if (cmd.div_init) begin
      dcnt_r <= '0;
      quo_r  <= '0;
      if (cmd.div_sel) begin
        rem_r     <= '0;
        nlo_r     <= frac_num;
        divisor_r <= tpe_pkg::TIME_W'(next_tab - base_tab);
      end else begin
        rem_r     <= num_r[tpe_pkg::NUM_W-1:tpe_pkg::QUO_W];
        nlo_r     <= num_r[tpe_pkg::QUO_W-1:0];
        divisor_r <= transit_r;
      end
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      nlo_r  <= {nlo_r[tpe_pkg::QUO_W-2:0], 1'b0};
      quo_r  <= {quo_r[tpe_pkg::QUO_W-2:0], qbit};
      rem_r  <= qbit ? tpe_pkg::TIME_W'(trial - {1'b0, divisor_r})
                     : trial[tpe_pkg::TIME_W-1:0];
    end
    // Target position and saturation at the table ends
    if (cmd.calc_tgt) begin
      tgt_r <= tgt_c;
      if (tgt_c == '0) begin
        decided_r <= 1'b1;
        res_ang_r <= '0;
      end else if (tgt_c >= tpe_pkg::POS_MAX) begin
        decided_r <= 1'b1;
        res_ang_r <= tpe_pkg::ANGLE_MAX;
      end
    end
    // Binary search for the last table entry at or below the target
    if (cmd.srch_init) begin
      lo_r   <= '0;
      scnt_r <= tpe_pkg::SRCH_CNT_W'(tpe_pkg::IDX_W - 1);
    end else if (cmd.srch_step) begin
      scnt_r <= scnt_r - 1'b1;
      if (cand <= tpe_pkg::IDX_W'(tpe_pkg::TABLE_LAST_INDEX - 1) &&
          cand_tab <= tgt_r[tpe_pkg::POS_W-1:8]) begin
        lo_r <= cand;
      end
    end
    if (cmd.calc_ang) res_ang_r <= {1'b0, lo_r, quo_r[7:0]};
    if (cmd.load_out) begin
      out_ang_r <= res_ang_r;
      out_unk_r <= res_unk_r;
    end
  end

  always_comb begin
    status.decided   = decided_r;
    status.div_last  = dcnt_r == tpe_pkg::DIV_LAST;
    status.srch_last = scnt_r == '0;
  end

  assign out_reached_angle   = out_ang_r;
  assign out_reached_unknown = out_unk_r;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt position estimator: a queue-fed driver
// offers queries with random gaps, a monitor compares each result against a
// bit-accurate predictor of the rule chain and the step-table interpolation.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [15:0] start_angle;
    logic        start_unknown;
    logic [15:0] dest_angle;
    logic        dest_unknown;
    logic [31:0] elapsed_time;
  } query_t;

  typedef struct packed {
    logic [15:0] reached_angle;
    logic        reached_unknown;
  } estimate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tpe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_start_angle = '0;
  logic in_start_unknown = 1'b0;
  logic [15:0] in_dest_angle = '0;
  logic in_dest_unknown = 1'b0;
  logic signed [31:0] in_elapsed_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_reached_angle;
  logic out_reached_unknown;

  tilt_position_estimator i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_angle(in_start_angle), .in_start_unknown(in_start_unknown),
    .in_dest_angle(in_dest_angle), .in_dest_unknown(in_dest_unknown),
    .in_elapsed_time(in_elapsed_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reached_angle(out_reached_angle),
    .out_reached_unknown(out_reached_unknown)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers
  logic [23:0] m_up_setup, m_down_setup;
  logic [15:0] m_up_step, m_down_step;
  logic [30:0] m_max_trans, m_max_cal;

  query_t    pending_q[$];
  estimate_t estimate_q[$];
  int  fail_cnt = 0;
  bit  hold_out = 1'b0;
  bit  sender_pause = 1'b0;

  int unsigned steps_rom[0:90] = '{
      0,   7,  14,  21,  28,  35,  42,  49,  56,  64,
     71,  78,  86,  93, 101, 109, 116, 125, 134, 141,
    150, 156, 165, 174, 183, 192, 201, 210, 218, 229,
    239, 248, 254, 267, 277, 287, 296, 306, 316, 326,
    336, 344, 356, 367, 377, 388, 398, 409, 417, 431,
    440, 453, 463, 474, 487, 498, 509, 519, 531, 541,
    554, 565, 576, 588, 599, 612, 622, 635, 647, 658,
    670, 681, 694, 706, 719, 730, 743, 754, 766, 779,
    791, 801, 812, 825, 838, 850, 860, 873, 884, 896,
    907};

  function automatic longint unsigned pos_of(input int unsigned a);
    int unsigned idx, frac;
    idx = a >> 8;
    frac = a & 255;
    if (idx >= 90) return longint'(steps_rom[90]) * 256;
    return longint'(steps_rom[idx]) * 256 + longint'(steps_rom[idx+1] - steps_rom[idx]) * frac;
  endfunction

  function automatic int unsigned angle_of(input longint unsigned t);
    int unsigned idx;
    longint unsigned span;
    idx = 0;
    if (t == 0) return 0;
    if (t >= longint'(steps_rom[90]) * 256) return 90 * 256;
    while (idx + 1 < 90 && longint'(steps_rom[idx+1]) * 256 <= t) idx++;
    span = steps_rom[idx+1] - steps_rom[idx];
    return idx * 256 + int'((t - longint'(steps_rom[idx]) * 256) / span);
  endfunction

  function automatic estimate_t estimate_position(input query_t q);
    estimate_t r;
    longint e, lim;
    longint unsigned setup, stept, ps, pd, dp, transit, ue, moved, tgt;
    bit up;
    e = longint'($signed(q.elapsed_time));
    lim = q.start_unknown ? longint'(m_max_cal) : longint'(m_max_trans);
    r.reached_unknown = 1'b1;
    r.reached_angle = '0;
    if (e >= lim) begin
      r.reached_unknown = q.dest_unknown;
      r.reached_angle = q.dest_unknown ? 16'd0 : q.dest_angle;
    end else if (q.start_unknown || q.dest_unknown || e < 0 ||
                 q.start_angle > 23040 || q.dest_angle > 23040) begin
      r.reached_unknown = 1'b1;
    end else begin
      up = q.start_angle < q.dest_angle;
      setup = up ? m_up_setup : m_down_setup;
      stept = up ? m_up_step : m_down_step;
      ps = pos_of(q.start_angle);
      pd = pos_of(q.dest_angle);
      dp = ps > pd ? ps - pd : pd - ps;
      transit = (stept * tpe_pkg::MOTOR_STEP_MULT * dp + 128) >> 8;
      ue = longint'(e);
      r.reached_unknown = 1'b0;
      if (ue >= setup + transit) r.reached_angle = q.dest_angle;
      else if (ue <= setup || transit == 0) r.reached_angle = q.start_angle;
      else begin
        moved = dp * (ue - setup) / transit;
        tgt = pd >= ps ? ps + moved : ps - moved;
        r.reached_angle = 16'(angle_of(tgt));
      end
    end
    return r;
  endfunction

  // Driver: offer the head of the queue, then wait a random gap after acceptance
  int gap_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        estimate_q.push_back(estimate_position(pending_q.pop_front()));
      end
      if (in_valid && !in_ready) begin
        // hold the offered transaction
      end else if (gap_cnt > 0) begin
        in_valid <= 1'b0;
        gap_cnt <= gap_cnt - 1;
      end else if (!sender_pause && pending_q.size() > 0) begin
        in_valid <= 1'b1;
        {in_start_angle, in_start_unknown, in_dest_angle, in_dest_unknown,
         in_elapsed_time} <= pending_q[0];
        gap_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) :
                   (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check results and randomize back-pressure
  always @(posedge clk) begin
    estimate_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected result angle=%0d unknown=%0b", $time,
                   out_reached_angle, out_reached_unknown);
          fail_cnt++;
        end else begin
          want = estimate_q.pop_front();
          if (out_reached_angle !== want.reached_angle) begin
            $display("%0t: reached_angle expected %0d actual %0d", $time,
                     want.reached_angle, out_reached_angle);
            fail_cnt++;
          end
          if (out_reached_unknown !== want.reached_unknown) begin
            $display("%0t: reached_unknown expected %0b actual %0b", $time,
                     want.reached_unknown, out_reached_unknown);
            fail_cnt++;
          end
        end
      end
      out_ready <= (hold_out || $urandom_range(0, 9) == 0 ||
                    $urandom_range(0, 60) == 0) ? 1'b0 : 1'b1;
    end
  end

  task automatic write_reg(input tpe_pkg::cfg_idx_t idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      tpe_pkg::CFG_UP_SETUP:   m_up_setup = val[23:0];
      tpe_pkg::CFG_DOWN_SETUP: m_down_setup = val[23:0];
      tpe_pkg::CFG_UP_STEP:    m_up_step = val[15:0];
      tpe_pkg::CFG_DOWN_STEP:  m_down_step = val[15:0];
      tpe_pkg::CFG_MAX_TRANS:  m_max_trans = val;
      tpe_pkg::CFG_MAX_CAL:    m_max_cal = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || in_valid || estimate_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic query_t rand_query();
    query_t q;
    int sel;
    q.start_angle = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23040));
    q.dest_angle = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23040));
    q.start_unknown = ($urandom_range(0, 9) == 0);
    q.dest_unknown = ($urandom_range(0, 9) == 0);
    sel = $urandom_range(0, 9);
    if (sel == 0) q.elapsed_time = $urandom;
    else if (sel == 1) q.elapsed_time = 32'($urandom_range(0, 400000));
    else q.elapsed_time = 32'($urandom_range(0, 2 * (m_up_setup > m_down_setup ?
                                   m_up_setup : m_down_setup) + 60000000));
    if (sel == 2) q.elapsed_time = 32'(m_up_setup);
    return q;
  endfunction

  task automatic add(input logic [15:0] s, input bit su, input logic [15:0] d,
                     input bit du, input logic [31:0] e);
    pending_q.push_back({s, su, d, du, e});
  endtask

  // Stimulus sequence
  initial begin
    m_up_setup = 24'd332192;  m_down_setup = 24'd333390;
    m_up_step = 16'd4269;     m_down_step = 16'd4291;
    m_max_trans = 31'd94850686; m_max_cal = 31'd130537866;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed: rule chain, extremes, direction, saturation
    add(16'd0, 0, 16'd23040, 0, 32'd94850686);
    add(16'd0, 1, 16'hFFFF, 0, 32'd130537866);
    add(16'd0, 1, 16'd100, 1, 32'h7FFFFFFF);
    add(16'd0, 0, 16'd23040, 0, 32'h80000000);
    add(16'd0, 0, 16'd23040, 0, 32'hFFFFFFFF);
    add(16'd23041, 0, 16'd0, 0, 32'd1000000);
    add(16'd0, 0, 16'd23041, 0, 32'd1000000);
    add(16'd0, 1, 16'd500, 0, 32'd1000000);
    add(16'd0, 0, 16'd500, 1, 32'd1000000);
    add(16'd0, 0, 16'd23040, 0, 32'd332192);
    add(16'd0, 0, 16'd23040, 0, 32'd0);
    add(16'd0, 0, 16'd23040, 0, 32'd332193);
    add(16'd0, 0, 16'd23040, 0, 32'd20000000);
    add(16'd23040, 0, 16'd0, 0, 32'd20000000);
    add(16'd23040, 0, 16'd0, 0, 32'd90000000);
    add(16'd5000, 0, 16'd5000, 0, 32'd400000);
    add(16'd8200, 0, 16'd8260, 0, 32'd334000);
    add(16'd255, 0, 16'd22785, 0, 32'd5000000);
    add(16'd22000, 0, 16'd300, 0, 32'd40000000);
    drain();
    // pressure: hold the receiver while the sender keeps offering
    hold_out = 1'b1;
    repeat (6) pending_q.push_back(rand_query());
    repeat (300) @(posedge clk);
    hold_out = 1'b0;
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(tpe_pkg::CFG_UP_SETUP, 31'd0); write_reg(tpe_pkg::CFG_DOWN_SETUP, 31'd0);
          write_reg(tpe_pkg::CFG_UP_STEP, 31'd1); write_reg(tpe_pkg::CFG_DOWN_STEP, 31'd1);
          write_reg(tpe_pkg::CFG_MAX_TRANS, 31'd0); write_reg(tpe_pkg::CFG_MAX_CAL, 31'd0);
        end
        1: begin
          write_reg(tpe_pkg::CFG_UP_SETUP, 31'hFFFFFF);
          write_reg(tpe_pkg::CFG_DOWN_SETUP, 31'hFFFFFF);
          write_reg(tpe_pkg::CFG_UP_STEP, 31'hFFFF); write_reg(tpe_pkg::CFG_DOWN_STEP, 31'hFFFF);
          write_reg(tpe_pkg::CFG_MAX_TRANS, 31'h7FFFFFFF);
          write_reg(tpe_pkg::CFG_MAX_CAL, 31'h7FFFFFFF);
        end
        2: begin
          write_reg(tpe_pkg::CFG_UP_SETUP, 31'd1000);
          write_reg(tpe_pkg::CFG_DOWN_SETUP, 31'd2000);
          write_reg(tpe_pkg::CFG_UP_STEP, 31'd3); write_reg(tpe_pkg::CFG_DOWN_STEP, 31'd5);
          write_reg(tpe_pkg::CFG_MAX_TRANS, 31'h7FFFFFFF);
          write_reg(tpe_pkg::CFG_MAX_CAL, 31'd500000);
        end
        3: begin
          write_reg(tpe_pkg::CFG_UP_SETUP, 31'($urandom));
          write_reg(tpe_pkg::CFG_DOWN_SETUP, 31'($urandom));
          write_reg(tpe_pkg::CFG_UP_STEP, 31'($urandom_range(1, 65535)));
          write_reg(tpe_pkg::CFG_DOWN_STEP, 31'($urandom_range(1, 65535)));
          write_reg(tpe_pkg::CFG_MAX_TRANS, 31'($urandom));
          write_reg(tpe_pkg::CFG_MAX_CAL, 31'($urandom));
        end
        default: begin
          write_reg(tpe_pkg::CFG_UP_SETUP, 31'd332192);
          write_reg(tpe_pkg::CFG_DOWN_SETUP, 31'd333390);
          write_reg(tpe_pkg::CFG_UP_STEP, 31'd4269);
          write_reg(tpe_pkg::CFG_DOWN_STEP, 31'd4291);
          write_reg(tpe_pkg::CFG_MAX_TRANS, 31'd94850686);
          write_reg(tpe_pkg::CFG_MAX_CAL, 31'd130537866);
        end
      endcase
      repeat (85) pending_q.push_back(rand_query());
      while (pending_q.size() > 40) @(posedge clk);
      // pause the sender until every result is back
      sender_pause = 1'b1;
      while (in_valid || estimate_q.size() > 0) @(posedge clk);
      sender_pause = 1'b0;
      drain();
    end
    if (fail_cnt == 0) $display("** tilt_position_estimator: PASSED **");
    else $display("** tilt_position_estimator: FAILED **");
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("** tilt_position_estimator: FAILED **");
    $finish;
  end
endmodule
